>>> sv/vgph_pkg.sv
// ============================================================================
// vgph_pkg
// Shared types and codes of the voxel grid point histogram unit.
// ============================================================================
package vgph_pkg;

    localparam int DATA_W    = 32;
    localparam int OUT_CNT_W = 16;
    localparam int RIDX_W    = 6;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;
    localparam int OPQ_DEPTH = 8;
    localparam int OPQ_PTR_W = 3;
    localparam int OPQ_CNT_W = 4;

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_VOXEL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd4;

    localparam logic [DATA_W-1:0] INV_VOXEL_RESET = 32'd65536;

    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_ADD   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        B_INIT   = 2'd0,
        B_IDLE   = 2'd1,
        B_ACCESS = 2'd2,
        B_CLEAR  = 2'd3
    } back_state_t;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] point_z;
        logic [RIDX_W-1:0]        read_i;
        logic [RIDX_W-1:0]        read_j;
        logic [RIDX_W-1:0]        read_k;
    } point_item_t;

    typedef struct packed {
        logic                 in_grid;
        logic [OUT_CNT_W-1:0] voxel_count;
        logic                 occupied;
        logic                 saturated;
    } result_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

endpackage

>>> sv/vgph_ram.sv
// ============================================================================
// vgph_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module vgph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 262144
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/vgph_queue.sv
// ============================================================================
// vgph_queue
// Short operation queue between the front and back sections.
// ============================================================================
module vgph_queue
    import vgph_pkg::*;
#(
    parameter int WIDTH = 20
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 pop,
    output logic [WIDTH-1:0]     rdata,
    output logic                 empty,
    output logic [OPQ_CNT_W-1:0] count
);

    logic [WIDTH-1:0]     entry_reg [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OPQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OPQ_CNT_W-1:0] count_reg, count_next;
    logic                 do_pop;

    assign empty  = (count_reg == '0);
    assign count  = count_reg;
    assign rdata  = entry_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/vgph_front.sv
// ============================================================================
// vgph_front
// Accepts items, bins points to voxel indices and classifies each command.
// Three pipeline stages: offset, scale, range check and row address.
// ============================================================================
module vgph_front
    import vgph_pkg::*;
#(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64,
    parameter int GRID_Z = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  point_item_t          item,
    input  logic [DATA_W-1:0]    origin_x,
    input  logic [DATA_W-1:0]    origin_y,
    input  logic [DATA_W-1:0]    origin_z,
    input  logic [DATA_W-1:0]    inv_voxel,
    input  back_status_t         status,
    input  logic [OPQ_CNT_W-1:0] q_count,
    output logic                 op_push,
    output op_kind_t             op_kind,
    output logic [(GRID_X*GRID_Y*GRID_Z > 1 ? $clog2(GRID_X*GRID_Y*GRID_Z) : 1)-1:0] op_addr
);

    localparam int TOTAL = GRID_X * GRID_Y * GRID_Z;
    localparam int XW    = GRID_X > 1 ? $clog2(GRID_X) : 1;
    localparam int YW    = GRID_Y > 1 ? $clog2(GRID_Y) : 1;
    localparam int ZW    = GRID_Z > 1 ? $clog2(GRID_Z) : 1;
    localparam int IJW   = GRID_X * GRID_Y > 1 ? $clog2(GRID_X * GRID_Y) : 1;
    localparam int AW    = TOTAL > 1 ? $clog2(TOTAL) : 1;
    localparam logic [DATA_W-1:0] GX_LIM = DATA_W'(GRID_X);
    localparam logic [DATA_W-1:0] GY_LIM = DATA_W'(GRID_Y);
    localparam logic [DATA_W-1:0] GZ_LIM = DATA_W'(GRID_Z);

    logic                 accept;
    logic [OPQ_CNT_W:0]   in_use;

    logic signed [DATA_W:0] diff    [3];
    logic signed [DATA_W:0] diff_ng [3];
    logic [DATA_W-1:0]      pnt     [3];
    logic [DATA_W-1:0]      org     [3];

    logic                 s1_valid_reg;
    logic [CMD_W-1:0]     s1_cmd_reg;
    logic [2:0]           s1_neg_reg;
    logic [DATA_W-1:0]    s1_mag_reg [3];
    logic [RIDX_W-1:0]    s1_ri_reg, s1_rj_reg, s1_rk_reg;

    logic                 s2_valid_reg;
    logic [CMD_W-1:0]     s2_cmd_reg;
    logic [2:0]           s2_neg_reg;
    logic [2*DATA_W-1:0]  s2_prod_reg [3];
    logic [RIDX_W-1:0]    s2_ri_reg, s2_rj_reg, s2_rk_reg;

    logic                 s3_valid_reg;
    op_kind_t             s3_kind_reg, s3_kind_next;
    logic [IJW-1:0]       s3_ij_reg, s3_ij_next;
    logic [ZW-1:0]        s3_k_reg, s3_k_next;

    logic [2:0]           axis_ok;
    logic [DATA_W-1:0]    quot [3];
    logic [DATA_W-1:0]    lim  [3];
    logic                 read_ok;
    logic [XW-1:0]        idx_i;
    logic [YW-1:0]        idx_j;
    logic [IJW:0]         ij_wide;
    logic [AW:0]          addr_wide;

    assign in_use = (OPQ_CNT_W+1)'(q_count) + (OPQ_CNT_W+1)'(s1_valid_reg)
                  + (OPQ_CNT_W+1)'(s2_valid_reg) + (OPQ_CNT_W+1)'(s3_valid_reg);
    assign full   = status.init_busy || (in_use >= (OPQ_CNT_W+1)'(OPQ_DEPTH));
    assign accept = push && !full;

    assign pnt[0] = item.point_x;
    assign pnt[1] = item.point_y;
    assign pnt[2] = item.point_z;
    assign org[0] = origin_x;
    assign org[1] = origin_y;
    assign org[2] = origin_z;
    assign lim[0] = GX_LIM;
    assign lim[1] = GY_LIM;
    assign lim[2] = GZ_LIM;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            diff[a]    = $signed({pnt[a][DATA_W-1], pnt[a]}) - $signed({org[a][DATA_W-1], org[a]});
            diff_ng[a] = -diff[a];
        end
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            quot[a]    = s2_prod_reg[a][2*DATA_W-1:DATA_W];
            axis_ok[a] = s2_neg_reg[a] ? (s2_prod_reg[a] == '0) : (quot[a] < lim[a]);
        end
        read_ok = (DATA_W'(s2_ri_reg) < GX_LIM) && (DATA_W'(s2_rj_reg) < GY_LIM)
               && (DATA_W'(s2_rk_reg) < GZ_LIM);

        unique case (s2_cmd_reg)
            CMD_ADD:   s3_kind_next = (&axis_ok) ? OP_ADD : OP_NONE;
            CMD_CLEAR: s3_kind_next = OP_CLEAR;
            CMD_READ:  s3_kind_next = read_ok ? OP_READ : OP_NONE;
            default:   s3_kind_next = OP_NONE;
        endcase

        if (s2_cmd_reg == CMD_READ)
        begin
            idx_i     = XW'(s2_ri_reg);
            idx_j     = YW'(s2_rj_reg);
            s3_k_next = ZW'(s2_rk_reg);
        end
        else
        begin
            idx_i     = quot[0][XW-1:0];
            idx_j     = quot[1][YW-1:0];
            s3_k_next = quot[2][ZW-1:0];
        end

        ij_wide    = (IJW+1)'(idx_i) * (IJW+1)'(GRID_Y) + (IJW+1)'(idx_j);
        s3_ij_next = ij_wide[IJW-1:0];
    end

    assign addr_wide = (AW+1)'(s3_ij_reg) * (AW+1)'(GRID_Z) + (AW+1)'(s3_k_reg);
    assign op_push   = s3_valid_reg;
    assign op_kind   = s3_kind_reg;
    assign op_addr   = addr_wide[AW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_cmd_reg <= item.command;
        s1_ri_reg  <= item.read_i;
        s1_rj_reg  <= item.read_j;
        s1_rk_reg  <= item.read_k;
        for (int a = 0; a < 3; a++)
        begin
            s1_neg_reg[a] <= diff[a][DATA_W];
            s1_mag_reg[a] <= diff[a][DATA_W] ? diff_ng[a][DATA_W-1:0] : diff[a][DATA_W-1:0];
        end

        s2_cmd_reg <= s1_cmd_reg;
        s2_neg_reg <= s1_neg_reg;
        s2_ri_reg  <= s1_ri_reg;
        s2_rj_reg  <= s1_rj_reg;
        s2_rk_reg  <= s1_rk_reg;
        for (int a = 0; a < 3; a++)
        begin
            s2_prod_reg[a] <= (2*DATA_W)'(s1_mag_reg[a]) * (2*DATA_W)'(inv_voxel);
        end

        s3_kind_reg <= s3_kind_next;
        s3_ij_reg   <= s3_ij_next;
        s3_k_reg    <= s3_k_next;
    end

endmodule

>>> sv/vgph_back.sv
// ============================================================================
// vgph_back
// Carries out queued operations on the voxel count store and holds the result.
// ============================================================================
module vgph_back
    import vgph_pkg::*;
#(
    parameter int GRID_X      = 64,
    parameter int GRID_Y      = 64,
    parameter int GRID_Z      = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    output logic                 q_pop,
    input  op_kind_t             q_kind,
    input  logic [(GRID_X*GRID_Y*GRID_Z > 1 ? $clog2(GRID_X*GRID_Y*GRID_Z) : 1)-1:0] q_addr,
    input  logic [OUT_CNT_W-1:0] threshold,
    output logic                 res_valid,
    input  logic                 res_pop,
    output result_t              result,
    output back_status_t         status
);

    localparam int TOTAL = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = TOTAL > 1 ? $clog2(TOTAL) : 1;
    localparam int CMPW  = COUNT_WIDTH > OUT_CNT_W ? COUNT_WIDTH : OUT_CNT_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TOTAL - 1);

    back_state_t          state_reg, state_next;
    logic [AW-1:0]        ptr_reg, ptr_next;
    op_kind_t             kind_reg, kind_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic                 go;
    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic [COUNT_WIDTH-1:0] mem_rdata;

    logic                 sat;
    logic [COUNT_WIDTH-1:0] incr;
    logic [COUNT_WIDTH-1:0] seen;
    logic [CMPW-1:0]      seen_ext;

    vgph_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TOTAL)
    ) u_count_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (q_addr),
        .rdata (mem_rdata)
    );

    assign go        = !q_empty && (!res_valid_reg || res_pop);
    assign sat       = (mem_rdata == '1);
    assign incr      = sat ? mem_rdata : mem_rdata + 1'b1;
    assign seen      = (kind_reg == OP_ADD) ? incr : mem_rdata;
    assign seen_ext  = CMPW'(seen);
    assign res_valid = res_valid_reg;
    assign result    = res_reg;
    assign status.init_busy = (state_reg == B_INIT);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_INIT:
            begin
                if (ptr_reg == LAST_ADDR)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (go && (q_kind == OP_CLEAR))
                begin
                    state_next = B_CLEAR;
                end
                else if (go && (q_kind != OP_NONE))
                begin
                    state_next = B_ACCESS;
                end
            end
            B_ACCESS:
            begin
                state_next = B_IDLE;
            end
            B_CLEAR:
            begin
                if (ptr_reg == LAST_ADDR)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = incr;
        unique case (state_reg) inside
            B_INIT, B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ptr_reg;
                mem_wdata = '0;
            end
            B_IDLE:
            begin
                q_pop = go;
            end
            B_ACCESS:
            begin
                mem_we = (kind_reg == OP_ADD);
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ptr_next       = ptr_reg;
        kind_next      = kind_reg;
        addr_next      = addr_reg;
        res_valid_next = res_valid_reg && !res_pop;
        res_next       = res_reg;
        unique case (state_reg)
            B_INIT:
            begin
                ptr_next = ptr_reg + 1'b1;
            end
            B_IDLE:
            begin
                ptr_next  = '0;
                kind_next = q_kind;
                addr_next = q_addr;
                if (go && (q_kind == OP_NONE))
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                end
            end
            B_ACCESS:
            begin
                res_valid_next       = 1'b1;
                res_next.in_grid     = (kind_reg == OP_ADD);
                res_next.saturated   = (kind_reg == OP_ADD) && sat;
                res_next.voxel_count = seen_ext[OUT_CNT_W-1:0];
                res_next.occupied    = (seen_ext > CMPW'(threshold));
            end
            B_CLEAR:
            begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_ADDR)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                end
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            ptr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        addr_reg <= addr_next;
        res_reg  <= res_next;
    end

endmodule

>>> sv/voxel_grid_point_histogram_unit.sv
// ============================================================================
// voxel_grid_point_histogram_unit
// Bins Q16.16 points into a voxel grid and keeps a saturating count per voxel.
//
//   channel   handshake        payload        beat accepted when
//   input     push / full      item           push && !full
//   result    empty / pop      result         pop && !empty
//   config    cfg_we           cfg_index/data cfg_we
//
// Front: 3-stage binning pipeline; back: an add or read passes IDLE (RAM read)
// and ACCESS (write back for an add); a clear zeroes every address in turn.
// After reset the store is cleared address by address; full is high meanwhile.
// full rises when the 8-entry operation queue plus pipeline holds 8 items.
// One result register: the back holds while it is occupied and not popped.
// ============================================================================
module voxel_grid_point_histogram_unit
    import vgph_pkg::*;
#(
    parameter int GRID_X      = 64,
    parameter int GRID_Y      = 64,
    parameter int GRID_Z      = 64,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  point_item_t          item,
    output logic                 empty,
    input  logic                 pop,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data
);

    localparam int TOTAL = GRID_X * GRID_Y * GRID_Z;
    localparam int AW    = TOTAL > 1 ? $clog2(TOTAL) : 1;
    localparam int OPW   = AW + 2;

    logic [DATA_W-1:0]    origin_x_reg, origin_y_reg, origin_z_reg, inv_voxel_reg;
    logic [OUT_CNT_W-1:0] threshold_reg;

    back_status_t         status;
    logic                 op_push;
    op_kind_t             op_kind;
    logic [AW-1:0]        op_addr;
    logic [OPW-1:0]       q_wdata, q_rdata;
    logic                 q_pop, q_empty;
    logic [OPQ_CNT_W-1:0] q_count;
    op_kind_t             q_kind;
    logic                 res_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            origin_z_reg  <= '0;
            inv_voxel_reg <= INV_VOXEL_RESET;
            threshold_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ORIGIN_X:  origin_x_reg  <= cfg_data;
                CFG_ORIGIN_Y:  origin_y_reg  <= cfg_data;
                CFG_ORIGIN_Z:  origin_z_reg  <= cfg_data;
                CFG_INV_VOXEL: inv_voxel_reg <= cfg_data;
                CFG_THRESHOLD: threshold_reg <= cfg_data[OUT_CNT_W-1:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    vgph_front #(
        .GRID_X (GRID_X),
        .GRID_Y (GRID_Y),
        .GRID_Z (GRID_Z)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .origin_x  (origin_x_reg),
        .origin_y  (origin_y_reg),
        .origin_z  (origin_z_reg),
        .inv_voxel (inv_voxel_reg),
        .status    (status),
        .q_count   (q_count),
        .op_push   (op_push),
        .op_kind   (op_kind),
        .op_addr   (op_addr)
    );

    assign q_wdata = {op_kind, op_addr};

    vgph_queue #(
        .WIDTH (OPW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .count (q_count)
    );

    assign q_kind = op_kind_t'(q_rdata[OPW-1:AW]);

    vgph_back #(
        .GRID_X      (GRID_X),
        .GRID_Y      (GRID_Y),
        .GRID_Z      (GRID_Z),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_kind    (q_kind),
        .q_addr    (q_rdata[AW-1:0]),
        .threshold (threshold_reg),
        .res_valid (res_valid),
        .res_pop   (pop),
        .result    (result),
        .status    (status)
    );

    assign empty = !res_valid;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the voxel grid point histogram unit.
// A scripted part hits reset reads, grid edges, out-of-grid points, the unused
// command, a burst of adds on one voxel and a clear. Random traffic follows
// under six register sets. Every result beat is compared field by field
// against a scripted expectation or an in-bench model of the voxel counters.
// ============================================================================
module tb_top;
    import vgph_pkg::*;

    localparam int GRID_DIM    = 64;
    localparam int SLOT_TOTAL  = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int STALL_LIMIT = 800_000;
    localparam int PHASE_ITEMS = 78;
    localparam int FILL_ADDS   = 20;

    localparam logic [CMD_W-1:0]     CMD_UNUSED = 2'd3;
    localparam logic [OUT_CNT_W-1:0] COUNT_MAX  = '1;

    typedef struct {
        point_item_t beat;
        int unsigned repeats;
        bit          typed;
        result_t     want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 push      = 1'b0;
    logic                 full;
    point_item_t          item      = '0;
    logic                 empty;
    logic                 pop       = 1'b0;
    result_t              result;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ORIGIN_X;
    logic [DATA_W-1:0]    cfg_data  = '0;

    logic [OUT_CNT_W-1:0]     voxel_tally [SLOT_TOTAL];
    logic signed [DATA_W-1:0] grid_origin [3];
    logic [DATA_W-1:0]        inv_voxel;
    logic [OUT_CNT_W-1:0]     occ_threshold;

    result_t     expected_results [$];
    int unsigned recent_slots [$];
    stim_row_t   script [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    int          mismatches     = 0;
    int          beats_sent     = 0;
    int          results_seen   = 0;
    int          grid_hits      = 0;
    int          saturated_hits = 0;

    voxel_grid_point_histogram_unit #(
        .GRID_X      (GRID_DIM),
        .GRID_Y      (GRID_DIM),
        .GRID_Z      (GRID_DIM),
        .COUNT_WIDTH (OUT_CNT_W)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic point_item_t mk_item(input logic [CMD_W-1:0] cmd,
                                            input logic [DATA_W-1:0] x, y, z,
                                            input logic [RIDX_W-1:0] i, j, k);
        point_item_t it;
        it.command = cmd;
        it.point_x = x;
        it.point_y = y;
        it.point_z = z;
        it.read_i  = i;
        it.read_j  = j;
        it.read_k  = k;
        return it;
    endfunction

    function automatic result_t mk_result(input logic in_grid, input logic [OUT_CNT_W-1:0] cnt,
                                          input logic occupied, input logic saturated);
        result_t r;
        r.in_grid     = in_grid;
        r.voxel_count = cnt;
        r.occupied    = occupied;
        r.saturated   = saturated;
        return r;
    endfunction

    // floor((p - o) * inv / 2^32) on one axis; 0 when outside the grid
    function automatic logic voxel_axis(input logic signed [DATA_W-1:0] p,
                                        input logic signed [DATA_W-1:0] o,
                                        output logic [RIDX_W-1:0] idx);
        longint          span;
        longint unsigned mag;
        longint unsigned prod;
        span = longint'(p) - longint'(o);
        mag  = (span < 0) ? -span : span;
        prod = mag * 64'(inv_voxel);
        idx  = '0;
        if (span < 0)
            return prod == 0;
        if ((prod >> 32) >= GRID_DIM)
            return 1'b0;
        idx = RIDX_W'(prod >> 32);
        return 1'b1;
    endfunction

    function automatic result_t tally_point(input point_item_t it);
        result_t           r;
        logic [RIDX_W-1:0] vi, vj, vk;
        logic              hx, hy, hz;
        int unsigned       slot;
        r = '0;
        case (it.command)
            CMD_ADD:
            begin
                hx = voxel_axis(it.point_x, grid_origin[0], vi);
                hy = voxel_axis(it.point_y, grid_origin[1], vj);
                hz = voxel_axis(it.point_z, grid_origin[2], vk);
                if (hx && hy && hz)
                begin
                    slot = {vi, vj, vk};
                    if (voxel_tally[slot] == COUNT_MAX)
                        r.saturated = 1'b1;
                    else
                        voxel_tally[slot] = voxel_tally[slot] + 1'b1;
                    r.in_grid     = 1'b1;
                    r.voxel_count = voxel_tally[slot];
                    r.occupied    = voxel_tally[slot] > occ_threshold;
                    recent_slots.insert(recent_slots.size(), slot);
                    if (recent_slots.size() > 32)
                        void'(recent_slots.pop_front());
                end
            end
            CMD_CLEAR:
                foreach (voxel_tally[n])
                    voxel_tally[n] = '0;
            CMD_READ:
            begin
                slot          = {it.read_i, it.read_j, it.read_k};
                r.voxel_count = voxel_tally[slot];
                r.occupied    = voxel_tally[slot] > occ_threshold;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] near_origin();
        return $urandom_range(0, 2097152) - 32'd1048576;
    endfunction

    // mostly aim at a voxel in the grid, often near the low corner, sometimes noise or edge values
    function automatic logic [DATA_W-1:0] pick_coord(input logic [DATA_W-1:0] o);
        int unsigned     pick;
        longint unsigned target;
        pick = $urandom_range(0, 99);
        if (pick < 80)
        begin
            target = {32'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                               : $urandom_range(0, GRID_DIM - 1)),
                      32'($urandom)};
            if (inv_voxel != 0)
                target = target / inv_voxel;
            else
                target = $urandom;
            return o + DATA_W'(target);
        end
        if (pick < 90)
            return $urandom;
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return o;
            3:       return o - 1;
            default: return o + 1;
        endcase
    endfunction

    function automatic point_item_t random_item();
        point_item_t it;
        int unsigned pick;
        it = mk_item(CMD_UNUSED, $urandom, $urandom, $urandom, RIDX_W'($urandom_range(0, 63)),
                     RIDX_W'($urandom_range(0, 63)), RIDX_W'($urandom_range(0, 63)));
        pick = $urandom_range(0, 99);
        if (pick < 70)
        begin
            it.command = CMD_ADD;
            it.point_x = pick_coord(grid_origin[0]);
            it.point_y = pick_coord(grid_origin[1]);
            it.point_z = pick_coord(grid_origin[2]);
        end
        else if (pick < 95)
        begin
            it.command = CMD_READ;
            if (recent_slots.size() != 0 && $urandom_range(0, 1))
                {it.read_i, it.read_j, it.read_k} =
                    18'(recent_slots[$urandom_range(0, recent_slots.size() - 1)]);
        end
        return it;
    endfunction

    task automatic add_row(input point_item_t beat, input int unsigned repeats,
                           input bit typed, input result_t want);
        stim_row_t row;
        row.beat    = beat;
        row.repeats = repeats;
        row.typed   = typed;
        row.want    = want;
        script.insert(script.size(), row);
    endtask

    task automatic send_item(input point_item_t it, input bit typed, input result_t want);
        result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predicted = tally_point(it);
        expected_results.insert(expected_results.size(), typed ? want : predicted);
        beats_sent++;
        if (predicted.in_grid)
            grid_hits++;
        if (predicted.saturated)
            saturated_hits++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic apply_config(input logic [DATA_W-1:0] ox, oy, oz, inv,
                                input logic [OUT_CNT_W-1:0] thr);
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_ORIGIN_Z, oz);
        write_reg(CFG_INV_VOXEL, inv);
        write_reg(CFG_THRESHOLD, DATA_W'(thr));
        cfg_we <= 1'b0;
        grid_origin[0] = ox;
        grid_origin[1] = oy;
        grid_origin[2] = oz;
        inv_voxel      = inv;
        occ_threshold  = thr;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // result side: check the beat taken at this edge, then pick pop for the next one
    initial
    begin
        result_t want;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result beat: %p", result);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    results_seen++;
                    if (result.in_grid !== want.in_grid)
                    begin
                        $error("in_grid: expected %0d, got %0d", want.in_grid, result.in_grid);
                        mismatches++;
                    end
                    if (result.voxel_count !== want.voxel_count)
                    begin
                        $error("voxel_count: expected %0d, got %0d",
                               want.voxel_count, result.voxel_count);
                        mismatches++;
                    end
                    if (result.occupied !== want.occupied)
                    begin
                        $error("occupied: expected %0d, got %0d", want.occupied, result.occupied);
                        mismatches++;
                    end
                    if (result.saturated !== want.saturated)
                    begin
                        $error("saturated: expected %0d, got %0d",
                               want.saturated, result.saturated);
                        mismatches++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        int stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty) || cfg_we)
                stalled = 0;
            else
                stalled++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        foreach (voxel_tally[n])
            voxel_tally[n] = '0;
        grid_origin   = '{default: '0};
        inv_voxel     = INV_VOXEL_RESET;
        occ_threshold = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        add_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0), 1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_READ, 0, 0, 0, 63, 63, 63), 1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_ADD, 0, 0, 0, 0, 0, 0), 1, 1, mk_result(1, 1, 1, 0));
        add_row(mk_item(CMD_ADD, 32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF, 63, 63, 63),
                1, 1, mk_result(1, 2, 1, 0));
        add_row(mk_item(CMD_ADD, 32'h003F_FFFF, 32'h003F_FFFF, 32'h003F_FFFF, 0, 0, 0),
                1, 1, mk_result(1, 1, 1, 0));
        add_row(mk_item(CMD_ADD, 32'h0040_0000, 0, 0, 0, 0, 0), 1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_ADD, 0, 32'hFFFF_FFFF, 0, 0, 0, 0), 1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_ADD, 0, 0, 32'h7FFF_FFFF, 0, 0, 0), 1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0),
                1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_UNUSED, $urandom, $urandom, $urandom, 0, 0, 0),
                1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_READ, $urandom, $urandom, $urandom, 63, 63, 63),
                1, 1, mk_result(0, 1, 1, 0));
        add_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0), 1, 1, mk_result(0, 2, 1, 0));
        add_row(mk_item(CMD_ADD, $urandom, $urandom, $urandom, RIDX_W'($urandom_range(0, 63)),
                        RIDX_W'($urandom_range(0, 63)), RIDX_W'($urandom_range(0, 63))),
                1, 0, '0);
        add_row(mk_item(CMD_READ, $urandom, $urandom, $urandom, RIDX_W'($urandom_range(0, 63)),
                        RIDX_W'($urandom_range(0, 63)), RIDX_W'($urandom_range(0, 63))),
                1, 0, '0);
        add_row(mk_item(CMD_ADD, 0, 0, 0, 0, 0, 0), FILL_ADDS, 0, '0);
        add_row(mk_item(CMD_ADD, 0, 0, 0, 0, 0, 0), 1, 0, '0);
        add_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0), 1, 0, '0);
        add_row(mk_item(CMD_CLEAR, $urandom, $urandom, $urandom, 5, 9, 33),
                1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_READ, 0, 0, 0, 0, 0, 0), 1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_READ, 0, 0, 0, 63, 63, 63), 1, 1, mk_result(0, 0, 0, 0));
        add_row(mk_item(CMD_ADD, 32'h0005_0000, 32'h0020_8000, 32'h003F_0000, 0, 0, 0),
                1, 0, '0);

        foreach (script[r])
            repeat (script[r].repeats)
                send_item(script[r].beat, script[r].typed, script[r].want);
        push <= 1'b0;
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 59 : 0;
            recv_idle_pct = (phase < 2) ? 59 : (phase < 4) ? 20 : 0;
            case (phase)
                0: apply_config(near_origin(), near_origin(), near_origin(),
                                INV_VOXEL_RESET, 1);
                1: apply_config(near_origin(), near_origin(), near_origin(),
                                $urandom_range(16384, 262144), 0);
                2: apply_config($urandom, $urandom, $urandom, 0, 16'hFFFF);
                3: apply_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'hFFFF_FFFF, 2);
                4: apply_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                $urandom, OUT_CNT_W'($urandom_range(0, 65535)));
                default: apply_config(near_origin(), near_origin(), near_origin(),
                                      $urandom_range(16384, 262144), 0);
            endcase
            repeat (PHASE_ITEMS)
                send_item(random_item(), 1'b0, '0);
            push <= 1'b0;
            wait_drained();
        end

        repeat (16) @(posedge clk);
        $display("Sent %0d items: %0d binned into the grid, %0d hit a full counter",
                 beats_sent, grid_hits, saturated_hits);
        $display("Checked %0d results over six register sets, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> voxel_grid_point_histogram_unit.f
sv/vgph_pkg.sv
sv/vgph_ram.sv
sv/vgph_queue.sv
sv/vgph_front.sv
sv/vgph_back.sv
sv/voxel_grid_point_histogram_unit.sv
bench/tb_top.sv
